>>> sv/olids_pkg.sv
// Package for the ordered list unit: command and status codes, controller states
// and the structs that pass between the controller and the datapath.
// No dependencies.
package olids_pkg;

  // Default number of list entries.
  localparam int OLIDS_CAPACITY = 16;

  // Operation codes carried on the kind port.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_key;
    logic    ins;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    commit_del;
    logic    finish;
    status_t fin_status;
    logic    fin_hit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic cmp_hit;
    logic cmp_last;
    logic shift_last;
  } dp_stat_t;

endpackage

>>> sv/olids_dp.sv
// Datapath of the ordered list unit: entry memory held as a ring, head pointer,
// fill count, scan and shift indexes and the result registers.
// Depends on olids_pkg.
module olids_dp
  import olids_pkg::*;
#(
  parameter int CAPACITY = OLIDS_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [31:0] value,
  output dp_stat_t    stat,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  position
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_S  = (IW + 1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  // Entry storage, indexed by physical slot.
  logic [31:0] mem [CAPACITY];

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [31:0]   key;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] cmp_idx;
  logic          cmp_valid;
  logic [31:0]   rd_data;
  logic [IW-1:0] mv_idx;
  logic [IW-1:0] wr_idx;
  logic          wr_pend;

  logic [IW-1:0] head_dec;
  logic [IW-1:0] head_inc;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          mv_nz;

  // Maps a position from the front to a physical slot of the ring.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [IW-1:0] idx);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[IW-1:0];
  endfunction

  assign head_dec = (head == '0) ? LAST_I : head - IW'(1);
  assign head_inc = (head == LAST_I) ? '0 : head + IW'(1);
  assign mv_nz    = (mv_idx != '0);

  // Status towards the controller.
  assign stat.full       = (count == CAP_C);
  assign stat.empty      = (count == '0);
  assign stat.cmp_hit    = cmp_valid && (rd_data == key);
  assign stat.cmp_last   = cmp_valid && (CW'(cmp_idx) == count - CW'(1));
  assign stat.shift_last = !mv_nz && !wr_pend;

  // Read port selection: scanning forward or moving entries back by one.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.scan_step) begin
      rd_en   = 1'b1;
      rd_addr = phys(head, scan_idx[IW-1:0]);
    end else if (cmd.shift_step && mv_nz) begin
      rd_en   = 1'b1;
      rd_addr = phys(head, mv_idx - IW'(1));
    end
  end

  // Write port selection: a new front entry, or the pending moved entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    if (cmd.ins) begin
      wr_en   = 1'b1;
      wr_addr = head_dec;
      wr_data = value;
    end else if (wr_pend) begin
      wr_en   = 1'b1;
      wr_addr = phys(head, wr_idx);
    end
  end

  // Entry memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Head pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.ins) begin
      head  <= head_dec;
      count <= count + CW'(1);
    end else if (cmd.commit_del) begin
      head  <= head_inc;
      count <= count - CW'(1);
    end
  end

  // Scan and shift sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      wr_pend   <= 1'b0;
      scan_idx  <= '0;
      mv_idx    <= '0;
    end else begin
      if (cmd.scan_start) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx  <= scan_idx + CW'(1);
        cmp_valid <= 1'b1;
      end
      if (cmd.shift_start) begin
        mv_idx  <= cmp_idx;
        wr_pend <= 1'b0;
      end else if (cmd.shift_step) begin
        wr_pend <= mv_nz;
        if (mv_nz) begin
          mv_idx <= mv_idx - IW'(1);
        end
      end
    end
  end

  // Payload registers that need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= value;
    end
    if (cmd.scan_step) begin
      cmp_idx <= scan_idx[IW-1:0];
    end
    if (cmd.shift_step && mv_nz) begin
      wr_idx <= mv_idx;
    end
  end

  // Result beat: strobe for one cycle with status and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      status   <= cmd.fin_status;
      position <= cmd.fin_hit ? 4'(cmp_idx) : 4'd0;
    end
  end

endmodule

>>> sv/olids_ctrl.sv
// Controller of the ordered list unit: accepts commands and sequences the
// datapath through the scan and the gap-closing shift. Depends on olids_pkg.
module olids_ctrl
  import olids_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] kind,
  input  dp_stat_t   stat,
  output logic       busy,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   is_delete;
  logic   accept;

  assign accept = start && (state == S_IDLE);

  // State register and the remembered operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_delete <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        is_delete <= (kind == KIND_DELETE);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (kind == KIND_DELETE || kind == KIND_SEARCH) && !stat.empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.cmp_hit) begin
          state_next = is_delete ? S_SHIFT : S_IDLE;
        end else if (stat.cmp_last) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (stat.shift_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands and busy.
  always_comb begin
    cmd            = '0;
    cmd.fin_status = ST_OK;
    busy           = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_INSERT: begin
              cmd.finish = 1'b1;
              if (stat.full) begin
                cmd.fin_status = ST_FULL;
              end else begin
                cmd.ins = 1'b1;
              end
            end
            KIND_DELETE, KIND_SEARCH: begin
              cmd.load_key = 1'b1;
              if (stat.empty) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_MISSING;
              end else begin
                cmd.scan_start = 1'b1;
              end
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat.cmp_hit) begin
          if (is_delete) begin
            cmd.shift_start = 1'b1;
          end else begin
            cmd.finish  = 1'b1;
            cmd.fin_hit = 1'b1;
          end
        end else if (stat.cmp_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_MISSING;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_last) begin
          cmd.commit_del = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_hit    = 1'b1;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/ordered_list_insert_delete_search_unit.sv
// Ordered list unit: newest-first list of 32-bit values with insert, delete and search.
// Insert and unused codes finish in the cycle that accepts them; the result beat follows on the next cycle.
// Search and delete scan the stored entries from the front through the registered read port of the entry
// memory, and delete then closes the gap with the one-entry-a-cycle gap shift.
// Reset (rst, synchronous) empties the list at once; memory contents are not cleared.
// Results are strobed on done for one cycle each and cannot be held off.
module ordered_list_insert_delete_search_unit
  import olids_pkg::*;
#(
  parameter int CAPACITY = OLIDS_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  position
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Command sequencing.
  olids_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Storage, indexes and result registers.
  olids_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (value),
    .stat     (stat),
    .done     (done),
    .status   (status),
    .position (position)
  );

endmodule

>>> sv/olids_checker.sv
// Port-level checker for the ordered list unit, bound to the top level.
// Depends on olids_pkg.
module olids_checker
  import olids_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind,
  input logic       done,
  input logic [1:0] status,
  input logic [3:0] position
);

  // An insert beat always gives its result on the next cycle.
  a_insert_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_INSERT |=> done)
    else $error("insert result not delivered on the next cycle");

  // Leaving a scan or shift always delivers a result.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  // A failed command reports position zero.
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> position == 4'd0)
    else $error("non-zero position on a failed command");

  // A full report only follows an insert accepted the cycle before.
  a_full_src: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> $past(start && !busy && kind == KIND_INSERT))
    else $error("full status without a preceding insert");

endmodule

bind ordered_list_insert_delete_search_unit olids_checker u_chk (.*);

>>> tb/ordered_list_insert_delete_search_unit_tb.sv
// Testbench for the ordered list unit: directed edge cases, then random fill/drain and mixed traffic.
// Results are predicted by a behavioural copy of the list and checked beat by beat.
// Depends on olids_pkg and ordered_list_insert_delete_search_unit.
module ordered_list_insert_delete_search_unit_tb
  import olids_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = OLIDS_CAPACITY;
  // Operation code that the unit must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 16;

  // One predicted result beat, with the command that caused it.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    status_t     status;
    logic [3:0]  position;
  } list_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_INSERT;
  logic [31:0] value = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  position;

  // Behavioural copy of the list contents, newest first.
  logic [31:0]   model_entries [LIST_DEPTH];
  int            model_count = 0;
  list_outcome_t awaited_outcomes[$];
  list_outcome_t head_outcome;
  int            fail_count = 0;
  bit            burst_mode = 1'b0;

  ordered_list_insert_delete_search_unit #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .done(done),
    .status(status),
    .position(position)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Safety net against a hung handshake.
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Count a failure and report the first few in detail.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] FAIL: %s", $realtime, msg);
    end
  endtask

  // Apply one command to the behavioural list and return the result it should give.
  function automatic list_outcome_t apply_list_op(input logic [1:0] op, input logic [31:0] key);
    list_outcome_t res;
    int            hit;
    res.op = op;
    res.key = key;
    res.status = ST_OK;
    res.position = '0;
    hit = -1;
    for (int i = 0; i < model_count; i++) begin
      if (hit < 0 && model_entries[i] == key) hit = i;
    end
    case (op)
      KIND_INSERT: begin
        if (model_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = model_count; i > 0; i--) model_entries[i] = model_entries[i - 1];
          model_entries[0] = key;
          model_count++;
        end
      end
      KIND_DELETE, KIND_SEARCH: begin
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.position = 4'(hit);
          if (op == KIND_DELETE) begin
            for (int i = hit; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
            model_count--;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // A value for insertion, biased towards extremes and a small pool that gives duplicates.
  function automatic logic [31:0] fresh_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'hFFFF_FFFF;
      3: v = 32'($urandom_range(0, 7));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // A key for delete or search: mostly one that is stored, sometimes one that is likely absent.
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    if (model_count > 0 && $urandom_range(0, 3) != 0) begin
      k = model_entries[$urandom_range(0, model_count - 1)];
    end else begin
      k = fresh_value();
    end
    return k;
  endfunction

  // Send one command beat after a random pause (none in burst mode); returns at the edge that accepts it.
  task automatic send_command(input logic [1:0] op, input logic [31:0] key);
    int gap;
    if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= op;
    value <= key;
    do @(posedge clk); while (busy !== 1'b0);
    awaited_outcomes.push_back(apply_list_op(op, key));
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (awaited_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result status %0d position %0d", status, position));
      end else begin
        head_outcome = awaited_outcomes.pop_front();
        if (status !== head_outcome.status || position !== head_outcome.position) begin
          note_failure($sformatf("kind %0d value %h: status exp %0d got %0d, position exp %0d got %0d",
                                 head_outcome.op, head_outcome.key, head_outcome.status, status,
                                 head_outcome.position, position));
        end
      end
    end
  end

  // Commands on an empty list, including the ignored code.
  task automatic test_empty_list();
    send_command(KIND_SEARCH, 32'h0000_0000);
    send_command(KIND_DELETE, 32'h0000_0000);
    send_command(KIND_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity with extremes and duplicates, overfill once, then probe front, middle and back.
  task automatic test_fill_and_edges();
    logic [31:0] seed_values [6];
    seed_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001};
    for (int i = 0; i < LIST_DEPTH; i++) begin
      send_command(KIND_INSERT, (i < 6) ? seed_values[i] : $urandom);
    end
    send_command(KIND_INSERT, 32'h1234_5678);
    send_command(KIND_SEARCH, 32'h8000_0000);
    send_command(KIND_DELETE, model_entries[model_count - 1]);
    send_command(KIND_DELETE, model_entries[0]);
    send_command(KIND_DELETE, 32'h0000_0000);
    send_command(KIND_SEARCH, 32'h0000_0000);
    send_command(KIND_UNUSED, 32'h0000_0000);
  endtask

  // Random traffic that swings the list between empty and full.
  task automatic test_fill_drain(input int n_items);
    bit growing;
    growing = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (growing && model_count == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && model_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        if (growing) send_command(KIND_INSERT, fresh_value());
        else send_command(KIND_DELETE, pick_key());
      end else begin
        send_command($urandom_range(0, 1) ? KIND_SEARCH : KIND_DELETE, pick_key());
      end
    end
  endtask

  // Random mix of all codes with random content.
  task automatic test_mixed_traffic(input int n_items);
    int roll;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) send_command(KIND_INSERT, fresh_value());
      else if (roll < 70) send_command(KIND_DELETE, pick_key());
      else if (roll < 96) send_command(KIND_SEARCH, pick_key());
      else send_command(KIND_UNUSED, $urandom);
    end
  endtask

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_and_edges();
    test_fill_drain(800);
    test_mixed_traffic(800);
    start <= 1'b0;

    // Let the last result beats arrive, then give the unit time to settle.
    waited = 0;
    while (awaited_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_outcomes.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", awaited_outcomes.size()));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
